[src/pfa_pkg.sv]
// Shared constants and types for the partition fit allocator.
// Depends on nothing; imported by pfa_scan and partition_fit_allocator.
package pfa_pkg;

   // Table geometry
   localparam int PARTITIONS = 8;
   localparam int IDX_W      = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
   localparam int CNT_W      = $clog2(PARTITIONS + 1);
   localparam int SIZE_W     = 16;

   // Request function codes
   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_ALLOC  = 2'd2;

   // Fit policy codes (the unused code behaves as first fit)
   localparam logic [1:0] POLICY_FIRST = 2'd0;
   localparam logic [1:0] POLICY_BEST  = 2'd1;
   localparam logic [1:0] POLICY_WORST = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT    = 2'd1;
   localparam logic [1:0] STATUS_LOADED    = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   // Control from the sequencer to the scan unit
   typedef struct packed {
      logic             start;  // any new request taken: drop the previous pick
      logic             valid;  // entry data from the table is present
      logic [IDX_W-1:0] idx;    // index of that entry
      logic             used;   // used mark of that entry
   } scan_ctrl_type;

endpackage

[src/pfa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/pfa_scan.sv]
// Fit scan unit: looks at one table entry per cycle and keeps the running pick.
// Depends on pfa_pkg.
module pfa_scan
   import pfa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  scan_ctrl_type       ctrl,
   input  logic [SIZE_W-1:0]   entry_size,
   input  logic [SIZE_W-1:0]   req_size,
   input  logic [1:0]          policy,
   output logic                found,
   output logic [IDX_W-1:0]    pick,
   output logic [SIZE_W-1:0]   pick_left
);

   logic              found_ff, found_in;
   logic [IDX_W-1:0]  pick_ff, pick_in;
   logic [SIZE_W-1:0] left_ff, left_in;
   logic              fits;
   logic [SIZE_W-1:0] left;
   logic              take;

   // Fit test for the entry in hand
   assign fits = ctrl.valid && !ctrl.used && (entry_size >= req_size);
   assign left = entry_size - req_size;

   // Policy decision; ties keep the earlier (lower) index
   always_comb begin
      case (policy)
         POLICY_BEST: begin
            take = fits && (!found_ff || (left < left_ff));
         end
         POLICY_WORST: begin
            take = fits && (!found_ff || (left > left_ff));
         end
         default: begin
            take = fits && !found_ff;
         end
      endcase
   end

   always_comb begin
      found_in = found_ff;
      pick_in  = pick_ff;
      left_in  = left_ff;
      if (ctrl.start) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         pick_in  = ctrl.idx;
         left_in  = left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      pick_ff <= pick_in;
      left_ff <= left_in;
   end

   assign found     = found_ff;
   assign pick      = pick_ff;
   assign pick_left = left_ff;

endmodule

[src/partition_fit_allocator.sv]
// Partition fit allocator: clear, append and first/best/worst fit allocate.
// A clear or append goes from idle to finish, where its response is registered;
// an allocate first scans the loaded entries of the partition size RAM, one entry
// per cycle, then goes to finish; finish waits while the response slot is stalled.
// Requests are served one at a time; req_stall drops as the response becomes valid.
// Reset (synchronous): policy, fill count and used marks go to zero; size RAM not cleared.
module partition_fit_allocator
   import pfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_size,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_partition_index,
   output logic [15:0] rsp_leftover,
   // policy register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        policy_ff, policy_in;
   logic [1:0]        func_ff, func_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PARTITIONS-1:0] used_ff, used_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [2:0]        rsp_index_ff, rsp_index_in;
   logic [15:0]       rsp_left_ff, rsp_left_in;

   logic              req_take;
   logic              slot_free;
   logic              issuing;
   logic              table_full;
   logic              finish_go;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [SIZE_W-1:0] ram_wr_data;
   logic [SIZE_W-1:0] ram_rd_data;

   scan_ctrl_type     scan_ctrl;
   logic              scan_found;
   logic [IDX_W-1:0]  scan_pick;
   logic [SIZE_W-1:0] scan_left;

   // Handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign table_full = (count_ff >= CNT_W'(PARTITIONS));
   assign issuing    = (state_ff == ST_SCAN) && (issue_ff < count_ff);
   assign finish_go  = (state_ff == ST_FINISH) && slot_free;

   // Partition size table
   pfa_ram #(
      .WIDTH (SIZE_W),
      .DEPTH (PARTITIONS)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (issuing),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Scan unit sees read data in the cycle after the address
   assign scan_ctrl.start = req_take;
   assign scan_ctrl.valid = rd_valid_ff;
   assign scan_ctrl.idx   = rd_idx_ff;
   assign scan_ctrl.used  = used_ff[rd_idx_ff];

   pfa_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (scan_ctrl),
      .entry_size (ram_rd_data),
      .req_size   (size_ff),
      .policy     (policy_ff),
      .found      (scan_found),
      .pick       (scan_pick),
      .pick_left  (scan_left)
   );

   // Sequencer; table writes only happen in finish, after all reads of the
   // request are done, so reads and writes never overlap on an entry
   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      size_in     = size_ff;
      issue_in    = issue_ff;
      rd_valid_in = issuing;
      rd_idx_in   = issue_ff[IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               func_in  = req_func;
               size_in  = req_size;
               issue_in = '0;
               case (req_func)
                  FUNC_CLEAR, FUNC_APPEND: state_in = ST_FINISH;
                  FUNC_ALLOC:              state_in = ST_SCAN;
                  default:                 state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (issuing) begin
               issue_in = issue_ff + CNT_W'(1);
            end else if (!rd_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commit of the table update and the response
   always_comb begin
      count_in      = count_ff;
      used_in       = used_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = count_ff[IDX_W-1:0];
      ram_wr_data   = size_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (finish_go) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = '0;
         rsp_left_in  = '0;
         case (func_ff)
            FUNC_CLEAR: begin
               count_in      = '0;
               used_in       = '0;
               rsp_status_in = STATUS_LOADED;
            end
            FUNC_APPEND: begin
               if (table_full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  ram_wr_en                    = 1'b1;
                  used_in[count_ff[IDX_W-1:0]] = 1'b0;
                  count_in                     = count_ff + CNT_W'(1);
                  rsp_status_in                = STATUS_LOADED;
                  rsp_index_in                 = 3'(count_ff);
               end
            end
            default: begin
               if (!scan_found) begin
                  rsp_status_in = STATUS_NO_FIT;
               end else begin
                  rsp_status_in = STATUS_ALLOCATED;
                  rsp_index_in  = 3'(scan_pick);
                  rsp_left_in   = scan_left;
                  if (policy_ff == POLICY_BEST) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = scan_pick;
                     ram_wr_data = scan_left;
                  end else begin
                     used_in[scan_pick] = 1'b1;
                  end
               end
            end
         endcase
      end
   end

   // Policy register
   assign policy_in = (csr_valid && csr_ready) ? csr_data : policy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= POLICY_FIRST;
         count_ff     <= '0;
         used_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      size_ff       <= size_in;
      issue_ff      <= issue_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_left_ff   <= rsp_left_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_partition_index = rsp_index_ff;
   assign rsp_leftover        = rsp_left_ff;

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(PARTITIONS))
      else $error("fill count beyond table depth");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_SCAN))
      else $error("table read data outside of a scan");

   a_pick_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && scan_found) |-> (CNT_W'(scan_pick) < count_ff))
      else $error("pick beyond loaded partitions");

   a_finish_emits: assert property (@(posedge clock) disable iff (reset)
      finish_go |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("finish did not produce a response");

endmodule
